FILE: rtl/hmsct_pkg.sv
// ---------------------------------------------------------------------------
// hmsct_pkg
// types, command codes and constants for the h:m:s countdown timer
// ---------------------------------------------------------------------------
package hmsct_pkg;

  localparam logic [9:0] MS_PER_SEC = 10'd1000;
  localparam logic [4:0] MAX_HOURS  = 5'd24;
  localparam logic [5:0] MAX_MINSEC = 6'd59;
  localparam logic [5:0] SEC_PER_MIN = 6'd60;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_INC   = 3'd1,
    CMD_DEC   = 3'd2,
    CMD_START = 3'd3,
    CMD_PAUSE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    FIELD_HOURS   = 2'd0,
    FIELD_MINUTES = 2'd1,
    FIELD_SECONDS = 2'd2
  } field_t;

  typedef enum logic [2:0] {
    REG_TICK_MS       = 3'd0,
    REG_REPEAT_ENABLE = 3'd1,
    REG_BREAK_ENABLE  = 3'd2,
    REG_BREAK_HOURS   = 3'd3,
    REG_BREAK_MINUTES = 3'd4,
    REG_BREAK_SECONDS = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [9:0] millis;
  } hms_time_t;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] field_select;
  } in_t;

  typedef struct packed {
    logic [4:0] hours_now;
    logic [5:0] minutes_now;
    logic [5:0] seconds_now;
    logic [9:0] millis_now;
    logic       is_running;
    logic       is_break;
    logic       finished;
  } out_t;

endpackage

FILE: rtl/hmsct_tick.sv
// ---------------------------------------------------------------------------
// hmsct_tick
// subtracts tick_ms from an h:m:s.ms time with a borrow cascade, clamps at zero
// ---------------------------------------------------------------------------
module hmsct_tick (
  input  hmsct_pkg::hms_time_t cur,
  input  logic [9:0]           tick_ms,
  output hmsct_pkg::hms_time_t nxt,
  output logic                 zero
);
  import hmsct_pkg::*;

  logic [11:0] diff;
  logic [11:0] diff_p1;
  logic [11:0] diff_p2;
  logic [9:0]  ms;
  logic [2:0]  sadj;
  logic [7:0]  s2;
  logic [5:0]  sec;
  logic [1:0]  madj;
  logic [7:0]  m2;
  logic [5:0]  mins;
  logic [1:0]  hadj;
  logic [7:0]  h2;

  assign diff    = {2'b00, cur.millis} - {2'b00, tick_ms};
  assign diff_p1 = diff + {2'b00, MS_PER_SEC};
  assign diff_p2 = diff + {1'b0, MS_PER_SEC, 1'b0};

  // millisecond borrow: up to two seconds, or a carry out of a loaded 1000
  always_comb begin
    if (diff == {2'b00, MS_PER_SEC}) begin
      ms   = '0;
      sadj = 3'sd1;
    end else if (!diff[11]) begin
      ms   = diff[9:0];
      sadj = 3'd0;
    end else if (!diff_p1[11]) begin
      ms   = diff_p1[9:0];
      sadj = 3'b111;
    end else begin
      ms   = diff_p2[9:0];
      sadj = 3'b110;
    end
  end

  assign s2 = {2'b00, cur.seconds} + {{5{sadj[2]}}, sadj};

  always_comb begin
    if (s2[7]) begin
      sec  = 6'(s2 + {2'b00, SEC_PER_MIN});
      madj = 2'b11;
    end else if (s2 >= {2'b00, SEC_PER_MIN}) begin
      sec  = 6'(s2 - {2'b00, SEC_PER_MIN});
      madj = 2'b01;
    end else begin
      sec  = s2[5:0];
      madj = 2'b00;
    end
  end

  assign m2 = {2'b00, cur.minutes} + {{6{madj[1]}}, madj};

  always_comb begin
    if (m2[7]) begin
      mins = 6'(m2 + {2'b00, SEC_PER_MIN});
      hadj = 2'b11;
    end else if (m2 >= {2'b00, SEC_PER_MIN}) begin
      mins = 6'(m2 - {2'b00, SEC_PER_MIN});
      hadj = 2'b01;
    end else begin
      mins = m2[5:0];
      hadj = 2'b00;
    end
  end

  assign h2 = {3'b000, cur.hours} + {{6{hadj[1]}}, hadj};

  // negative total clamps to zero
  always_comb begin
    if (h2[7]) begin
      nxt = '0;
    end else begin
      nxt.hours   = h2[4:0];
      nxt.minutes = mins;
      nxt.seconds = sec;
      nxt.millis  = ms;
    end
  end

  assign zero = (nxt == '0);

endmodule

FILE: rtl/hmsct_out_buf.sv
// ---------------------------------------------------------------------------
// hmsct_out_buf
// result register with a skid slot, stall toward the input only when both full
// ---------------------------------------------------------------------------
module hmsct_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hmsct_pkg::out_t   push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output hmsct_pkg::out_t   out_data
);
  import hmsct_pkg::*;

  logic skid_valid;
  out_t skid_data;
  logic pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

FILE: rtl/hms_countdown_timer_with_break.sv
// ---------------------------------------------------------------------------
// hms_countdown_timer_with_break
// h:m:s.ms countdown with field adjust, start, pause, repeat and break phases
// ---------------------------------------------------------------------------
// One command word is taken per clock while in_stall is low; its result word
// is registered in the output register, or in the skid slot behind it while
// the output is stalled. The whole update (borrow cascade of a tick, field
// wrap of an adjust, reload on reaching zero) is one combinational pass from
// the time registers, so sustained rate is one word per cycle while out_stall
// is low. in_stall rises only when both slots hold a word. Configuration
// writes are always ready and take effect on the next command.
// ---------------------------------------------------------------------------
module hms_countdown_timer_with_break (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  hmsct_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output hmsct_pkg::out_t  out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [9:0]       cfg_data
);
  import hmsct_pkg::*;

  logic [9:0] tick_ms;
  logic       repeat_enable;
  logic       break_enable;
  logic [4:0] break_hours;
  logic [5:0] break_minutes;
  logic [5:0] break_seconds;

  hms_time_t  count;
  hms_time_t  count_next;
  logic       running;
  logic       running_next;
  logic       break_phase;
  logic       break_phase_next;
  logic       break_shown;
  logic       break_shown_next;
  logic [4:0] start_hours;
  logic [4:0] start_hours_next;
  logic [5:0] start_minutes;
  logic [5:0] start_minutes_next;
  logic [5:0] start_seconds;
  logic [5:0] start_seconds_next;
  logic       fin;

  hms_time_t  tick_time;
  logic       tick_zero;
  logic       accept;
  out_t       result;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ms       <= 10'd16;
      repeat_enable <= 1'b0;
      break_enable  <= 1'b0;
      break_hours   <= 5'd0;
      break_minutes <= 6'd10;
      break_seconds <= 6'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TICK_MS:       tick_ms       <= cfg_data;
        REG_REPEAT_ENABLE: repeat_enable <= cfg_data[0];
        REG_BREAK_ENABLE:  break_enable  <= cfg_data[0];
        REG_BREAK_HOURS:   break_hours   <= (cfg_data[4:0] > MAX_HOURS) ? MAX_HOURS
                                                                          : cfg_data[4:0];
        REG_BREAK_MINUTES: break_minutes <= (cfg_data[5:0] > MAX_MINSEC) ? MAX_MINSEC
                                                                           : cfg_data[5:0];
        REG_BREAK_SECONDS: break_seconds <= (cfg_data[5:0] > MAX_MINSEC) ? MAX_MINSEC
                                                                           : cfg_data[5:0];
        default: ;
      endcase
    end
  end

  hmsct_tick u_tick (
    .cur     (count),
    .tick_ms (tick_ms),
    .nxt     (tick_time),
    .zero    (tick_zero)
  );

  always_comb begin
    count_next         = count;
    running_next       = running;
    break_phase_next   = break_phase;
    break_shown_next   = break_shown;
    start_hours_next   = start_hours;
    start_minutes_next = start_minutes;
    start_seconds_next = start_seconds;
    fin                = 1'b0;
    case (cmd_t'(in_data.command))
      CMD_TICK: begin
        if (running) begin
          count_next = tick_time;
          if (tick_zero) begin
            fin              = 1'b1;
            break_shown_next = 1'b0;
            if (break_enable && !break_phase) begin
              break_shown_next = 1'b1;
              break_phase_next = 1'b1;
              count_next       = '{break_hours, break_minutes, break_seconds, MS_PER_SEC};
            end else if (repeat_enable) begin
              break_phase_next = 1'b0;
              count_next       = '{start_hours, start_minutes, start_seconds, MS_PER_SEC};
            end else begin
              running_next     = 1'b0;
              break_phase_next = 1'b0;
            end
          end
        end
      end
      CMD_INC, CMD_DEC: begin
        if (!running) begin
          case (field_t'(in_data.field_select))
            FIELD_HOURS: begin
              if (in_data.command == CMD_INC) begin
                count_next.hours = (count.hours >= MAX_HOURS) ? 5'd0 : count.hours + 5'd1;
              end else begin
                count_next.hours = (count.hours == 5'd0) ? MAX_HOURS : count.hours - 5'd1;
              end
            end
            FIELD_MINUTES: begin
              if (in_data.command == CMD_INC) begin
                count_next.minutes = (count.minutes >= MAX_MINSEC) ? 6'd0
                                                                    : count.minutes + 6'd1;
              end else begin
                count_next.minutes = (count.minutes == 6'd0) ? MAX_MINSEC
                                                              : count.minutes - 6'd1;
              end
            end
            FIELD_SECONDS: begin
              if (in_data.command == CMD_INC) begin
                count_next.seconds = (count.seconds >= MAX_MINSEC) ? 6'd0
                                                                    : count.seconds + 6'd1;
              end else begin
                count_next.seconds = (count.seconds == 6'd0) ? MAX_MINSEC
                                                              : count.seconds - 6'd1;
              end
            end
            default: ;
          endcase
          count_next.millis = MS_PER_SEC;
        end
      end
      CMD_START: begin
        if (!running && ({count.hours, count.minutes, count.seconds} != '0)) begin
          start_hours_next   = count.hours;
          start_minutes_next = count.minutes;
          start_seconds_next = count.seconds;
          running_next       = 1'b1;
        end
      end
      CMD_PAUSE: begin
        running_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      running     <= 1'b0;
      break_phase <= 1'b0;
      break_shown <= 1'b0;
    end else if (accept) begin
      count       <= count_next;
      running     <= running_next;
      break_phase <= break_phase_next;
      break_shown <= break_shown_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_hours   <= start_hours_next;
      start_minutes <= start_minutes_next;
      start_seconds <= start_seconds_next;
    end
  end

  assign result = '{
    hours_now:   count_next.hours,
    minutes_now: count_next.minutes,
    seconds_now: count_next.seconds,
    millis_now:  count_next.millis,
    is_running:  running_next,
    is_break:    break_shown_next,
    finished:    fin
  };

  hmsct_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/hmsct_checker.sv
// ---------------------------------------------------------------------------
// hmsct_checker
// port-level checks on the countdown timer, bound to the top level
// ---------------------------------------------------------------------------
module hmsct_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input hmsct_pkg::out_t  out_data
);
  import hmsct_pkg::*;

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

  // a finish either reloads a full second or stops at zero
  a_finish_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.finished |->
      (out_data.millis_now == MS_PER_SEC) ||
      (!out_data.is_running && out_data.hours_now == 5'd0 &&
       out_data.minutes_now == 6'd0 && out_data.seconds_now == 6'd0 &&
       out_data.millis_now == 10'd0))
    else $error("finish without reload or stop");

  // millis never beyond one loaded second, hours never beyond one carry past max
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.millis_now <= MS_PER_SEC) &&
                  (out_data.hours_now <= MAX_HOURS + 5'd1) &&
                  (out_data.minutes_now <= MAX_MINSEC) &&
                  (out_data.seconds_now <= MAX_MINSEC))
    else $error("time field out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind hms_countdown_timer_with_break hmsct_checker u_hmsct_checker (.*);
